// File: hdl/hmgc_pkg.sv
// ----------------------------------------------------------------------------
// hmgc_pkg: shared types and constants of the heightmap gouge check
// Field widths, register indexes, reset values, command codes and the
// sequencer states used by the core, its divider and its height store.
// ----------------------------------------------------------------------------
`default_nettype none

package hmgc_pkg;

  // field widths
  localparam int POS_W      = 24;
  localparam int CMD_W      = 2;
  localparam int RAD_W      = 16;
  localparam int SIZE_W     = 23;
  localparam int CELLS_W    = 10;
  localparam int CELL_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  // datapath widths
  localparam int MUL_W  = 27;
  localparam int PROD_W = 54;
  localparam int NUM_W  = 48;
  localparam int DEN_W  = 25;
  localparam int SQ_W   = 48;

  // default bounds
  localparam int DEF_MAX_CELLS_X     = 512;
  localparam int DEF_MAX_CELLS_Z     = 512;
  localparam int DEF_MAX_WINDOW_HALF = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOOL_RADIUS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z      = 3'd5;

  // register reset values
  localparam logic [POS_W-1:0]   RST_BASE_HEIGHT = 24'd5248;
  localparam logic [RAD_W-1:0]   RST_TOOL_RADIUS = 16'd1024;
  localparam logic [SIZE_W-1:0]  RST_BLOCK_SIZE  = 23'd38400;
  localparam logic [CELLS_W-1:0] RST_CELLS       = 10'd500;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BAKE  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // divide jobs run on the shared divider
  typedef enum logic [2:0] {
    J_GX, J_GZ, J_HX, J_HZ, J_SX, J_SZ, J_CX0, J_CZ0
  } job_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_MUL, S_DIV_LOAD, S_DIV_RUN, S_DIV_POST,
    S_BAKE_CHK, S_BAKE_WR, S_WIN, S_R2, S_ROW, S_ROW_SQ,
    S_CELL, S_CELL_D2, S_CELL_CMP, S_CELL_NEXT, S_ROW_NEXT, S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: hdl/hmgc_ram.sv
// ----------------------------------------------------------------------------
// hmgc_ram: generic single-clock RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hmgc_ram
  import hmgc_pkg::*;
#(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = DEF_MAX_CELLS_X * DEF_MAX_CELLS_Z
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/hmgc_div.sv
// ----------------------------------------------------------------------------
// hmgc_div: unsigned restoring divider
// One quotient bit a cycle; busy stays high from start until the last quotient bit is in.
// ----------------------------------------------------------------------------
`default_nettype none

module hmgc_div
  import hmgc_pkg::*;
#(
  parameter int NW = NUM_W,
  parameter int DW = DEN_W
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quot,
  output logic [DW-1:0]      rem
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    acc;
  logic [DW-1:0]    dsr;
  logic [DW:0]      shifted;
  logic [DW+1:0]    trial;

  assign shifted = {acc, quot[NW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr};
  assign rem     = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NW);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      quot <= num;
      dsr  <= den;
    end else if (busy) begin
      if (!trial[DW+1]) begin
        acc  <= trial[DW-1:0];
        quot <= {quot[NW-2:0], 1'b1};
      end else begin
        acc  <= shifted[DW-1:0];
        quot <= {quot[NW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/heightmap_tool_gouge_check_core.sv
// ----------------------------------------------------------------------------
// heightmap_tool_gouge_check_core: ball-end tool gouge check on a heightmap
// Keeps a grid of protected heights and checks tool positions against it.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on s_tvalid/s_tready; s_tuser carries the command (clear,
//   bake, check), s_tdata the position and the line start flag. Every item
//   gives exactly one result item on m_tvalid/m_tready.
//   Registers are written on cfg_valid/cfg_ready (always ready); the user
//   must do so only while idle, unchecked by the block. One item is worked
//   at a time; s_tready is high only when the sequencer is idle. A finished
//   result sits in the output register, so the next item is taken while it
//   waits; a stalled receiver holds the block at its next finish.
//   Steps per command:
//     clear : every store cell gets the base height, one RAM write a cycle
//     bake  : two divides, read, write
//     check : divides on the shared divider, then a walk over the window
//             rows and cells (up to 33 x 33 cells)
//   Reset restores the register defaults and clears the segment flag. The
//   height store is not swept at reset; it holds nothing useful until the
//   first clear command.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_tool_gouge_check_core
  import hmgc_pkg::*;
#(
  parameter int MAX_CELLS_X     = DEF_MAX_CELLS_X,
  parameter int MAX_CELLS_Z     = DEF_MAX_CELLS_Z,
  parameter int MAX_WINDOW_HALF = DEF_MAX_WINDOW_HALF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input items
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // pos_x[23:0], pos_y[47:24], pos_z[71:48], line_start[72], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // command[1:0]
  input  wire logic [CMD_W-1:0]      s_tuser,
  // result items
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // damaged[0], keep_point[1], segment_start[2], out_x[26:3],
  // out_y[50:27], out_z[74:51], zero fill
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_CELLS_X * MAX_CELLS_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_CELLS_X + 1);
  localparam int ZW    = $clog2(MAX_CELLS_Z + 1);
  localparam int RXW   = XW + 1;
  localparam int RZW   = ZW + 1;
  localparam int HW    = $clog2(MAX_WINDOW_HALF + 1);
  localparam int CW    = NUM_W + 1;
  localparam int CMP_W = SQ_W + 16;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0]   base_height;
  logic        [RAD_W-1:0]   tool_radius;
  logic        [SIZE_W-1:0]  block_size_x;
  logic        [SIZE_W-1:0]  block_size_z;
  logic        [CELLS_W-1:0] cells_x;
  logic        [CELLS_W-1:0] cells_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_height  <= RST_BASE_HEIGHT;
      tool_radius  <= RST_TOOL_RADIUS;
      block_size_x <= RST_BLOCK_SIZE;
      block_size_z <= RST_BLOCK_SIZE;
      cells_x      <= RST_CELLS;
      cells_z      <= RST_CELLS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_HEIGHT:  base_height  <= cfg_data;
        REG_TOOL_RADIUS:  tool_radius  <= cfg_data[RAD_W-1:0];
        REG_BLOCK_SIZE_X: block_size_x <= cfg_data[SIZE_W-1:0];
        REG_BLOCK_SIZE_Z: block_size_z <= cfg_data[SIZE_W-1:0];
        REG_CELLS_X:      cells_x      <= cfg_data[CELLS_W-1:0];
        REG_CELLS_Z:      cells_z      <= cfg_data[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective grid: zero counts as one, counts clamp to the store size
  logic [XW-1:0]     cx_eff;
  logic [ZW-1:0]     cz_eff;
  logic [SIZE_W-1:0] bx_eff;
  logic [SIZE_W-1:0] bz_eff;

  always_comb begin
    if (cells_x == '0) begin
      cx_eff = XW'(1);
    end else if (32'(cells_x) > MAX_CELLS_X) begin
      cx_eff = XW'(MAX_CELLS_X);
    end else begin
      cx_eff = XW'(cells_x);
    end
    if (cells_z == '0) begin
      cz_eff = ZW'(1);
    end else if (32'(cells_z) > MAX_CELLS_Z) begin
      cz_eff = ZW'(MAX_CELLS_Z);
    end else begin
      cz_eff = ZW'(cells_z);
    end
    bx_eff = (block_size_x == '0) ? SIZE_W'(1) : block_size_x;
    bz_eff = (block_size_z == '0) ? SIZE_W'(1) : block_size_z;
  end

  logic signed [CW-1:0] rad_fx;
  assign rad_fx = $signed(CW'({tool_radius, 8'h00}));

  // --------------------------------------------------------------------------
  // item registers and working state
  // --------------------------------------------------------------------------
  state_t state, state_next;
  job_t   job, job_next;

  logic signed [POS_W-1:0] px, py, pz;
  logic                    line_start;
  cmd_t                    cmd;
  logic                    in_segment;
  logic                    hit;

  logic signed [CW-1:0] gx, gz;
  logic [HW-1:0]        hx, hz;
  logic [XW-1:0]        xlo, xhi, x;
  logic [ZW-1:0]        zlo, zhi, z;
  logic [AW-1:0]        row_base;
  logic [AW-1:0]        clr_addr;
  logic [SQ_W-1:0]      r2, dz2, vrem;
  logic                 diff_pos;

  // cell centres as quotient and floor remainder, stepped per cell
  logic signed [CW-1:0] qsx, qsz, cx0q, cxq, czq;
  logic [RXW-1:0]       rsx, cx0r, cxr;
  logic [RZW-1:0]       rsz, czr;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // shared divider
  logic                    div_start, div_busy, div_neg;
  logic [NUM_W-1:0]        div_num, div_quot;
  logic [DEN_W-1:0]        div_den, div_rem;
  logic signed [PROD_W-1:0] nval;

  hmgc_div #(
    .NW (NUM_W),
    .DW (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // height store
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr, bake_addr;
  logic [CELL_W-1:0] wr_data, rd_data;

  hmgc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // divider set-up and post-processing per job
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (job) inside
      J_HX:       nval = prod + $signed(PROD_W'(bx_eff)) - PROD_W'(1);
      J_HZ:       nval = prod + $signed(PROD_W'(bz_eff)) - PROD_W'(1);
      J_CX0, J_CZ0: nval = prod <<< 8;
      default:    nval = prod;
    endcase
    unique case (job) inside
      J_GX:       div_den = DEN_W'({bx_eff, 1'b0});
      J_GZ:       div_den = DEN_W'({bz_eff, 1'b0});
      J_HX:       div_den = DEN_W'(bx_eff);
      J_HZ:       div_den = DEN_W'(bz_eff);
      J_SX, J_CX0: div_den = DEN_W'({cx_eff, 1'b0});
      default:    div_den = DEN_W'({cz_eff, 1'b0});
    endcase
    div_num = nval[PROD_W-1] ? NUM_W'(-nval) : NUM_W'(nval);
  end

  logic signed [CW-1:0] q_trunc, q_floor;
  logic [DEN_W-1:0]     r_floor;

  always_comb begin
    q_trunc = div_neg ? -$signed(CW'(div_quot)) : $signed(CW'(div_quot));
    q_floor = q_trunc;
    r_floor = div_rem;
    if (div_neg && (div_rem != '0)) begin
      q_floor = q_trunc - CW'(1);
      r_floor = div_den - div_rem;
    end
  end

  // --------------------------------------------------------------------------
  // window, distances and centre steps
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] xlo_w, xhi_w, zlo_w, zhi_w, xlo_c, xhi_c, zlo_c, zhi_c;
  logic                 win_empty;

  always_comb begin
    xlo_w = gx - $signed(CW'(hx));
    xhi_w = gx + $signed(CW'(hx)) + CW'(1);
    zlo_w = gz - $signed(CW'(hz));
    zhi_w = gz + $signed(CW'(hz)) + CW'(1);
    xlo_c = (xlo_w < 0) ? '0 : xlo_w;
    zlo_c = (zlo_w < 0) ? '0 : zlo_w;
    xhi_c = (xhi_w > $signed(CW'(cx_eff))) ? $signed(CW'(cx_eff)) : xhi_w;
    zhi_c = (zhi_w > $signed(CW'(cz_eff))) ? $signed(CW'(cz_eff)) : zhi_w;
    win_empty = (xlo_c >= xhi_c) || (zlo_c >= zhi_c);
  end

  logic signed [CW-1:0] dx_w, dz_w;
  logic                 dx_in, dz_in;
  logic [SQ_W:0]        d2;
  logic                 d2_over;
  logic signed [POS_W:0] diff;

  always_comb begin
    dx_w    = cxq - (CW'(px) <<< 8);
    dz_w    = czq - (CW'(pz) <<< 8);
    dx_in   = (dx_w <= rad_fx) && (dx_w >= -rad_fx);
    dz_in   = (dz_w <= rad_fx) && (dz_w >= -rad_fx);
    d2      = (SQ_W + 1)'(prod[SQ_W-1:0]) + (SQ_W + 1)'(dz2);
    d2_over = d2 > (SQ_W + 1)'(r2);
    diff    = (POS_W + 1)'($signed(rd_data)) - (POS_W + 1)'(py);
  end

  logic [RXW:0]         sum_rx;
  logic [RZW:0]         sum_rz;
  logic                 carry_x, carry_z;
  logic signed [CW-1:0] cxq_next, czq_next;
  logic [RXW-1:0]       cxr_next;
  logic [RZW-1:0]       czr_next;

  always_comb begin
    sum_rx   = (RXW + 1)'(cxr) + (RXW + 1)'(rsx);
    carry_x  = sum_rx >= (RXW + 1)'({cx_eff, 1'b0});
    cxq_next = cxq + qsx + (carry_x ? CW'(1) : CW'(0));
    cxr_next = carry_x ? RXW'(sum_rx - (RXW + 1)'({cx_eff, 1'b0})) : RXW'(sum_rx);
    sum_rz   = (RZW + 1)'(czr) + (RZW + 1)'(rsz);
    carry_z  = sum_rz >= (RZW + 1)'({cz_eff, 1'b0});
    czq_next = czq + qsz + (carry_z ? CW'(1) : CW'(0));
    czr_next = carry_z ? RZW'(sum_rz - (RZW + 1)'({cz_eff, 1'b0})) : RZW'(sum_rz);
  end

  logic bake_ok;
  assign bake_ok = (py >= base_height) &&
                   (gx >= 0) && (gx < $signed(CW'(cx_eff))) &&
                   (gz >= 0) && (gz < $signed(CW'(cz_eff)));
  assign bake_addr = AW'(gz[ZW-1:0]) * AW'(MAX_CELLS_X) + AW'(gx[XW-1:0]);

  logic out_load;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = bake_addr;
    wr_en      = 1'b0;
    wr_addr    = bake_addr;
    wr_data    = py;
    mul_a      = '0;
    mul_b      = '0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          job_next = J_GX;
          unique case (cmd_t'(s_tuser))
            CMD_CLEAR: state_next = S_CLEAR;
            CMD_BAKE:  state_next = S_MUL;
            CMD_CHECK: state_next = S_MUL;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = base_height;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_DONE;
        end
      end
      S_MUL: begin
        unique case (job) inside
          J_GX: begin
            mul_a = $signed(MUL_W'(cx_eff));
            mul_b = (MUL_W'(px) <<< 1) + $signed(MUL_W'(bx_eff));
          end
          J_GZ: begin
            mul_a = $signed(MUL_W'(cz_eff));
            mul_b = (MUL_W'(pz) <<< 1) + $signed(MUL_W'(bz_eff));
          end
          J_HX: begin
            mul_a = $signed(MUL_W'(tool_radius));
            mul_b = $signed(MUL_W'(cx_eff));
          end
          J_HZ: begin
            mul_a = $signed(MUL_W'(tool_radius));
            mul_b = $signed(MUL_W'(cz_eff));
          end
          J_SX: begin
            mul_a = $signed(MUL_W'(bx_eff));
            mul_b = MUL_W'(512);
          end
          J_SZ: begin
            mul_a = $signed(MUL_W'(bz_eff));
            mul_b = MUL_W'(512);
          end
          J_CX0: begin
            mul_a = ($signed(MUL_W'(xlo)) <<< 1) + MUL_W'(1) - $signed(MUL_W'(cx_eff));
            mul_b = $signed(MUL_W'(bx_eff));
          end
          default: begin
            mul_a = ($signed(MUL_W'(zlo)) <<< 1) + MUL_W'(1) - $signed(MUL_W'(cz_eff));
            mul_b = $signed(MUL_W'(bz_eff));
          end
        endcase
        state_next = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        div_start  = 1'b1;
        state_next = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (!div_busy) begin
          state_next = S_DIV_POST;
        end
      end
      S_DIV_POST: begin
        unique case (job)
          J_GX:  begin job_next = J_GZ;  state_next = S_MUL; end
          J_GZ:  begin
            if (cmd == CMD_BAKE) begin
              state_next = S_BAKE_CHK;
            end else begin
              job_next   = J_HX;
              state_next = S_MUL;
            end
          end
          J_HX:  begin job_next = J_HZ;  state_next = S_MUL; end
          J_HZ:  state_next = S_WIN;
          J_SX:  begin job_next = J_SZ;  state_next = S_MUL; end
          J_SZ:  begin job_next = J_CX0; state_next = S_MUL; end
          J_CX0: begin job_next = J_CZ0; state_next = S_MUL; end
          default: state_next = S_ROW;
        endcase
      end
      S_BAKE_CHK: begin
        rd_en      = bake_ok;
        state_next = bake_ok ? S_BAKE_WR : S_DONE;
      end
      S_BAKE_WR: begin
        wr_en      = py > $signed(rd_data);
        state_next = S_DONE;
      end
      S_WIN: begin
        mul_a      = MUL_W'(rad_fx);
        mul_b      = MUL_W'(rad_fx);
        state_next = win_empty ? S_DONE : S_R2;
      end
      S_R2: begin
        job_next   = J_SX;
        state_next = S_MUL;
      end
      S_ROW: begin
        mul_a      = MUL_W'(dz_w);
        mul_b      = MUL_W'(dz_w);
        state_next = dz_in ? S_ROW_SQ : S_ROW_NEXT;
      end
      S_ROW_SQ: begin
        state_next = S_CELL;
      end
      S_CELL: begin
        mul_a      = MUL_W'(dx_w);
        mul_b      = MUL_W'(dx_w);
        rd_en      = dx_in;
        rd_addr    = row_base + AW'(x);
        state_next = dx_in ? S_CELL_D2 : S_CELL_NEXT;
      end
      S_CELL_D2: begin
        mul_a      = MUL_W'(diff);
        mul_b      = MUL_W'(diff);
        state_next = d2_over ? S_CELL_NEXT : S_CELL_CMP;
      end
      S_CELL_CMP: begin
        state_next = S_CELL_NEXT;
      end
      S_CELL_NEXT: begin
        state_next = (x == xhi - XW'(1)) ? S_ROW_NEXT : S_CELL;
      end
      S_ROW_NEXT: begin
        state_next = (z == zhi - ZW'(1)) ? S_DONE : S_ROW;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    job <= job_next;
    unique case (state)
      S_IDLE: begin
        px         <= s_tdata[23:0];
        py         <= s_tdata[47:24];
        pz         <= s_tdata[71:48];
        line_start <= s_tdata[72];
        cmd        <= cmd_t'(s_tuser);
        hit        <= 1'b0;
        clr_addr   <= '0;
      end
      S_CLEAR: begin
        clr_addr <= clr_addr + AW'(1);
      end
      S_DIV_LOAD: begin
        div_neg <= nval[PROD_W-1];
      end
      S_DIV_POST: begin
        unique case (job)
          J_GX:  gx <= q_trunc;
          J_GZ:  gz <= q_trunc;
          J_HX:  hx <= (div_quot > NUM_W'(MAX_WINDOW_HALF)) ? HW'(MAX_WINDOW_HALF)
                                                            : HW'(div_quot);
          J_HZ:  hz <= (div_quot > NUM_W'(MAX_WINDOW_HALF)) ? HW'(MAX_WINDOW_HALF)
                                                            : HW'(div_quot);
          J_SX:  begin qsx <= q_trunc; rsx <= RXW'(div_rem); end
          J_SZ:  begin qsz <= q_trunc; rsz <= RZW'(div_rem); end
          J_CX0: begin cx0q <= q_floor; cx0r <= RXW'(r_floor); end
          default: begin
            czq <= q_floor;
            czr <= RZW'(r_floor);
          end
        endcase
      end
      S_WIN: begin
        xlo      <= XW'(xlo_c);
        xhi      <= XW'(xhi_c);
        zlo      <= ZW'(zlo_c);
        zhi      <= ZW'(zhi_c);
        z        <= ZW'(zlo_c);
        row_base <= AW'(zlo_c[ZW-1:0]) * AW'(MAX_CELLS_X);
      end
      S_R2: begin
        r2 <= prod[SQ_W-1:0];
      end
      S_ROW_SQ: begin
        dz2 <= prod[SQ_W-1:0];
        x   <= xlo;
        cxq <= cx0q;
        cxr <= cx0r;
      end
      S_CELL_D2: begin
        vrem     <= SQ_W'(r2 - d2[SQ_W-1:0]);
        diff_pos <= diff > 0;
      end
      S_CELL_CMP: begin
        if (diff_pos && (CMP_W'(vrem) < {prod[SQ_W-1:0], 16'h0000})) begin
          hit <= 1'b1;
        end
      end
      S_CELL_NEXT: begin
        x   <= x + XW'(1);
        cxq <= cxq_next;
        cxr <= cxr_next;
      end
      S_ROW_NEXT: begin
        z        <= z + ZW'(1);
        row_base <= row_base + AW'(MAX_CELLS_X);
        czq      <= czq_next;
        czr      <= czr_next;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // result register and segment tracking
  // --------------------------------------------------------------------------
  logic is_check, keep;
  assign is_check = (cmd == CMD_CHECK);
  assign keep     = is_check && !hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      in_segment <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        if (is_check) begin
          in_segment <= !hit;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // pack the result fields; drop the position of anything not kept
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_DATA_W'({keep ? pz : POS_W'(0),
                              keep ? py : POS_W'(0),
                              keep ? px : POS_W'(0),
                              keep && (line_start || !in_segment),
                              keep,
                              is_check && hit});
    end
  end

endmodule

`default_nettype wire
